>>> design/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the stereographic projection pipeline.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int COMP_W = 16;
    localparam int PROJ_W = 32;
    localparam int STAT_W = 2;
    localparam int SUM_W  = 33;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 34;
    localparam int SQ_N   = 32;
    localparam int NUM_W  = 47;
    localparam int DIV_N  = 47;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    localparam logic [PROJ_W-1:0] PROJ_MAX = 32'h7FFF_FFFF;
    localparam logic [PROJ_W-1:0] PROJ_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [COMP_W-1:0] c3;
        logic signed [COMP_W-1:0] c2;
        logic signed [COMP_W-1:0] c1;
        logic signed [COMP_W-1:0] c0;
    } comp_t;

endpackage

>>> design/sphere_stereographic_projection.sv
// ----------------------------------------------------------------------------
// sphere_stereographic_projection
// Projects a Q2.14 4D point, via the unit 3-sphere, into Q16.16 3D space.
// ----------------------------------------------------------------------------
// One point enters per clock while the skid buffer is empty: two stages
// form the sum of squares, 32 stages take the integer square root one
// result bit each, one stage forms the denominator, one the rounded dividend,
// and 47 stages per lane run a restoring divider one quotient bit each. The
// last stage feeds an output register backed by a one-beat skid buffer, so
// the input keeps flowing while one result waits to be taken.
module sphere_stereographic_projection
    import ssp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // comp_0, comp_1, comp_2, comp_3
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // proj_x, proj_y, proj_z
    output logic [1:0]   m_tuser    // status
);

    logic en;
    logic skid_vld_reg;
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // squares
    logic        a_vld_reg;
    comp_t       a_comp_reg;
    logic [30:0] a_sq_reg [4];
    comp_t       in_comp;
    assign in_comp = comp_t'(s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
        end
        if (en) begin
            a_comp_reg  <= in_comp;
            a_sq_reg[0] <= 31'(unsigned'(32'(in_comp.c0) * 32'(in_comp.c0)));
            a_sq_reg[1] <= 31'(unsigned'(32'(in_comp.c1) * 32'(in_comp.c1)));
            a_sq_reg[2] <= 31'(unsigned'(32'(in_comp.c2) * 32'(in_comp.c2)));
            a_sq_reg[3] <= 31'(unsigned'(32'(in_comp.c3) * 32'(in_comp.c3)));
        end
    end

    // square root pipeline, stage 0 holds the sum
    logic              sq_vld_reg  [SQ_N+1];
    comp_t             sq_comp_reg [SQ_N+1];
    logic [63:0]       sq_val_reg  [SQ_N+1];
    logic [ROOT_W-1:0] sq_root_reg [SQ_N+1];
    logic [REM_W-1:0]  sq_rem_reg  [SQ_N+1];
    logic [SUM_W-1:0]  sum_next;

    assign sum_next = SUM_W'(a_sq_reg[0]) + SUM_W'(a_sq_reg[1])
                    + SUM_W'(a_sq_reg[2]) + SUM_W'(a_sq_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= a_vld_reg;
        end
        if (en) begin
            sq_comp_reg[0] <= a_comp_reg;
            sq_val_reg[0]  <= {1'b0, sum_next, 30'd0};
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
        end
    end

    for (genvar i = 0; i < SQ_N; i++) begin : g_sq
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             take;
        logic [REM_W+1:0] diff;
        assign rem_sh = {sq_rem_reg[i], sq_val_reg[i][63:62]};
        assign trial  = (REM_W+2)'({sq_root_reg[i], 2'b01});
        assign take   = rem_sh >= trial;
        assign diff   = rem_sh - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[i+1] <= sq_vld_reg[i];
            end
            if (en) begin
                sq_comp_reg[i+1] <= sq_comp_reg[i];
                sq_val_reg[i+1]  <= {sq_val_reg[i][61:0], 2'b00};
                sq_root_reg[i+1] <= {sq_root_reg[i][ROOT_W-2:0], take};
                sq_rem_reg[i+1]  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            end
        end
    end

    // denominator
    logic              e_vld_reg;
    comp_t             e_comp_reg;
    logic [31:0]       e_d_reg;
    logic              e_pole_reg;
    logic signed [33:0] d_next;

    assign d_next = signed'({2'b00, sq_root_reg[SQ_N]})
                  - (34'(sq_comp_reg[SQ_N].c0) <<< 15);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= sq_vld_reg[SQ_N];
        end
        if (en) begin
            e_comp_reg <= sq_comp_reg[SQ_N];
            e_d_reg    <= d_next[31:0];
            e_pole_reg <= d_next[33] || (d_next == '0);
        end
    end

    // divider pipeline, stage 0 holds the rounded dividends
    logic             dv_vld_reg  [DIV_N+1];
    comp_t            dv_comp_reg [DIV_N+1];
    logic [31:0]      dv_d_reg    [DIV_N+1];
    logic             dv_pole_reg [DIV_N+1];
    logic [NUM_W-1:0] dv_num_reg  [DIV_N+1][3];
    logic [31:0]      dv_rem_reg  [DIV_N+1][3];
    logic signed [COMP_W-1:0] e_lane [3];

    assign e_lane[0] = e_comp_reg.c1;
    assign e_lane[1] = e_comp_reg.c2;
    assign e_lane[2] = e_comp_reg.c3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= e_vld_reg;
        end
        if (en) begin
            dv_comp_reg[0] <= e_comp_reg;
            dv_d_reg[0]    <= e_d_reg;
            dv_pole_reg[0] <= e_pole_reg;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane0
        logic [COMP_W:0] mag;
        assign mag = e_lane[l][COMP_W-1] ? (COMP_W+1)'(-17'(e_lane[l]))
                                         : (COMP_W+1)'(e_lane[l]);
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_num_reg[0][l] <= {mag[15:0], 31'd0} + NUM_W'(e_d_reg >> 1);
                dv_rem_reg[0][l] <= '0;
            end
        end
    end

    for (genvar i = 0; i < DIV_N; i++) begin : g_dv
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[i+1] <= dv_vld_reg[i];
            end
            if (en) begin
                dv_comp_reg[i+1] <= dv_comp_reg[i];
                dv_d_reg[i+1]    <= dv_d_reg[i];
                dv_pole_reg[i+1] <= dv_pole_reg[i];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_l
            logic [32:0] rem_sh;
            logic        take;
            logic [32:0] diff;
            assign rem_sh = {dv_rem_reg[i][l], dv_num_reg[i][l][NUM_W-1]};
            assign take   = rem_sh >= {1'b0, dv_d_reg[i]};
            assign diff   = rem_sh - {1'b0, dv_d_reg[i]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_num_reg[i+1][l] <= {dv_num_reg[i][l][NUM_W-2:0], take};
                    dv_rem_reg[i+1][l] <= take ? diff[31:0] : rem_sh[31:0];
                end
            end
        end
    end

    // final saturation and status
    comp_t       f_comp;
    logic        f_zero;
    logic [2:0]  f_sat;
    logic [PROJ_W-1:0] f_proj [3];
    logic signed [COMP_W-1:0] f_lane [3];
    logic [STAT_W-1:0] f_status;

    assign f_comp    = dv_comp_reg[DIV_N];
    assign f_zero    = (f_comp == '0);
    assign f_lane[0] = f_comp.c1;
    assign f_lane[1] = f_comp.c2;
    assign f_lane[2] = f_comp.c3;

    for (genvar l = 0; l < 3; l++) begin : g_fin
        logic [NUM_W-1:0] q;
        logic             neg;
        assign q   = dv_num_reg[DIV_N][l];
        assign neg = f_lane[l][COMP_W-1];
        always_comb begin
            if (neg) begin
                f_sat[l] = (q[NUM_W-1:32] != '0) || (q[31] && (q[30:0] != '0));
            end else begin
                f_sat[l] = (q[NUM_W-1:31] != '0);
            end
            if (f_zero) begin
                f_proj[l] = '0;
            end else if (dv_pole_reg[DIV_N] || f_sat[l]) begin
                f_proj[l] = neg ? PROJ_MIN : PROJ_MAX;
            end else if (neg) begin
                f_proj[l] = -q[31:0];
            end else begin
                f_proj[l] = q[31:0];
            end
        end
    end

    always_comb begin
        if (f_zero) begin
            f_status = STAT_ZERO;
        end else if (dv_pole_reg[DIV_N] || (f_sat != '0)) begin
            f_status = STAT_SAT;
        end else begin
            f_status = STAT_OK;
        end
    end

    // output register with skid beat
    logic              out_vld_reg;
    logic [95:0]       out_data_reg;
    logic [STAT_W-1:0] out_user_reg;
    logic [95:0]       skid_data_reg;
    logic [STAT_W-1:0] skid_user_reg;
    logic              last_vld;
    logic              out_free;

    assign last_vld = en && dv_vld_reg[DIV_N];
    assign out_free = !out_vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= last_vld;
            end
        end else if (last_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_vld_reg) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end else begin
                out_data_reg <= {f_proj[2], f_proj[1], f_proj[0]};
                out_user_reg <= f_status;
            end
        end else if (last_vld) begin
            skid_data_reg <= {f_proj[2], f_proj[1], f_proj[0]};
            skid_user_reg <= f_status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives 4D Q2.14 points into the stereographic projection pipeline and checks
// every Q16.16 result and status against an in-bench integer model of the
// length, denominator and rounded, saturated quotients. Directed corner points
// come first, then random points under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import ssp_pkg::*;

    localparam int N_RANDOM   = 1440;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_LEN  = 200;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [PROJ_W-1:0] z;
        logic [PROJ_W-1:0] y;
        logic [PROJ_W-1:0] x;
    } proj_res_t;

    typedef struct {
        comp_t     pt;
        bit        typed;
        proj_res_t res;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    proj_res_t pending_proj[$];
    stim_row_t stim_rows[$];
    int        err_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    int        quiet_cycles = 0;

    sphere_stereographic_projection dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic proj_res_t project_point(comp_t p);
        longint            c[4];
        longint unsigned   sq, rem, root, bitv, den, mag, q;
        longint            dsig;
        bit                neg, sat;
        logic [PROJ_W-1:0] lane[3];
        proj_res_t         r;
        c[0] = p.c0;
        c[1] = p.c1;
        c[2] = p.c2;
        c[3] = p.c3;
        sq = 0;
        for (int k = 0; k < 4; k++) sq += longint'(c[k] * c[k]);
        r.st = STAT_OK;
        if (sq == 0) begin
            lane[0] = '0; lane[1] = '0; lane[2] = '0;
            r.st = STAT_ZERO;
        end else begin
            // bitwise integer square root of sq * 2^30
            rem = sq << 30;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem) bitv >>= 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            dsig = longint'(root) - c[0] * 32768;
            if (dsig <= 0) begin
                for (int k = 0; k < 3; k++) lane[k] = (c[k+1] < 0) ? PROJ_MIN : PROJ_MAX;
                r.st = STAT_SAT;
            end else begin
                den = dsig;
                sat = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    neg = c[k+1] < 0;
                    mag = neg ? -c[k+1] : c[k+1];
                    q = ((mag << 31) + den / 2) / den;
                    if (neg && q > 64'h8000_0000) begin
                        q = 64'h8000_0000;
                        sat = 1'b1;
                    end else if (!neg && q > 64'h7FFF_FFFF) begin
                        q = 64'h7FFF_FFFF;
                        sat = 1'b1;
                    end
                    lane[k] = neg ? PROJ_W'(-q) : PROJ_W'(q);
                end
                if (sat) r.st = STAT_SAT;
            end
        end
        r.x = lane[0];
        r.y = lane[1];
        r.z = lane[2];
        return r;
    endfunction

    task automatic add_row(input int a, input int b, input int c, input int d, input bit typed,
                           input logic [PROJ_W-1:0] x = '0, input logic [PROJ_W-1:0] y = '0,
                           input logic [PROJ_W-1:0] z = '0, input logic [STAT_W-1:0] st = STAT_OK);
        stim_row_t row;
        row.pt.c0 = COMP_W'(a);
        row.pt.c1 = COMP_W'(b);
        row.pt.c2 = COMP_W'(c);
        row.pt.c3 = COMP_W'(d);
        row.typed = typed;
        row.res.x = x;
        row.res.y = y;
        row.res.z = z;
        row.res.st = st;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // one point per call, sender idles at random before offering the beat
    task automatic send_point(input comp_t pt, input proj_res_t want);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tdata  <= pt;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_proj.insert(pending_proj.size(), want);
    endtask

    function automatic comp_t random_point();
        comp_t p;
        int    mode;
        mode = $urandom_range(9);
        p = comp_t'({$urandom, $urandom});
        if (mode == 0) begin
            // close to the pole: large positive comp_0, tiny others
            p.c0 = COMP_W'($urandom_range(32767, 12000));
            p.c1 = $signed(16'($urandom_range(15))) - 8;
            p.c2 = $signed(16'($urandom_range(15))) - 8;
            p.c3 = $signed(16'($urandom_range(15))) - 8;
        end else if (mode == 1) begin
            p.c0 = $signed(16'($urandom_range(7))) - 4;
            p.c1 = $signed(16'($urandom_range(7))) - 4;
            p.c2 = $signed(16'($urandom_range(7))) - 4;
            p.c3 = $signed(16'($urandom_range(7))) - 4;
        end else if (mode == 2) begin
            p = '0;
        end
        return p;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge aclk);
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        proj_res_t want;
        proj_res_t got;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.x  = m_tdata[31:0];
            got.y  = m_tdata[63:32];
            got.z  = m_tdata[95:64];
            got.st = m_tuser;
            if (pending_proj.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[31:0], '0);
            end else begin
                want = pending_proj.pop_front();
                if (got.x !== want.x) report_mismatch("proj_x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("proj_y", got.y, want.y);
                if (got.z !== want.z) report_mismatch("proj_z", got.z, want.z);
                if (got.st !== want.st) report_mismatch("status", 32'(got.st), 32'(want.st));
            end
        end
    end

    initial begin
        comp_t pt;
        add_row(0, 0, 0, 0, 1, '0, '0, '0, STAT_ZERO);
        add_row(16384, 0, 0, 0, 1, PROJ_MAX, PROJ_MAX, PROJ_MAX, STAT_SAT);
        add_row(32767, 0, 0, 0, 1, PROJ_MAX, PROJ_MAX, PROJ_MAX, STAT_SAT);
        add_row(1, 0, 0, 0, 1, PROJ_MAX, PROJ_MAX, PROJ_MAX, STAT_SAT);
        add_row(-32768, 0, 0, 0, 1, '0, '0, '0, STAT_OK);
        add_row(-1, 0, 0, 0, 1, '0, '0, '0, STAT_OK);
        add_row(0, 1, 0, 0, 1, 32'h0001_0000, '0, '0, STAT_OK);
        add_row(0, -1, 0, 0, 1, 32'hFFFF_0000, '0, '0, STAT_OK);
        add_row(0, -32768, 0, 0, 0);
        add_row(0, 32767, 32767, 32767, 0);
        add_row(-32768, -32768, -32768, -32768, 0);
        add_row(32767, -32768, 32767, -32768, 0);
        add_row(32767, 1, -1, 0, 0);
        add_row(32767, -1, 0, 1, 0);
        add_row(16384, -1, 1, -1, 0);
        add_row(16000, 100, -100, 50, 0);
        add_row(16'sh5555, 16'shAAAA - 65536, 16'sh5555, 16'shAAAA - 65536, 0);
        add_row(16'shAAAA - 65536, 16'sh5555, 16'shAAAA - 65536, 16'sh5555, 0);
        add_row(0, 0, 0, -32768, 0);
        add_row(-16384, 16384, -16384, 16384, 0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            send_point(stim_rows[i].pt,
                       stim_rows[i].typed ? stim_rows[i].res : project_point(stim_rows[i].pt));
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 23) : 0;
            recv_stall_pct = (ph == 2) ? 84 : ((ph == 3) ? 23 : 0);
            if (ph == 0) hold_req = 1'b1;
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                pt = random_point();
                send_point(pt, project_point(pt));
            end
        end
        s_tvalid <= 1'b0;

        while (pending_proj.size() != 0) @(posedge aclk);
        repeat (DRAIN_LEN) @(posedge aclk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
